// ===== rtl/cfa_pkg.sv =====
// shared types and constants of the checksummed encoder frame accumulator
package cfa_pkg;

  localparam int DATA_BYTES  = 8;
  localparam int PORT_COUNT  = 2;
  localparam int ENC_COUNT   = 2 * PORT_COUNT;
  localparam int QUEUE_DEPTH = 2;

  localparam int PORT_W   = 1;
  localparam int SEL_W    = 2;
  localparam int POS_W    = $clog2(DATA_BYTES + 1);
  localparam int BIDX_W   = $clog2(DATA_BYTES);
  localparam logic [7:0] SUM_MASK = 8'hFF;

  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 144;
  localparam int OUT_TUSER_W = 2;

  localparam logic OP_FRAME_BYTE = 1'b0;
  localparam logic OP_PRESET     = 1'b1;

  typedef enum logic {
    CMD_PRESET = 1'b0,
    CMD_FRAME  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                       kind;
    logic [PORT_W-1:0]               port;
    logic                            good;
    logic [SEL_W-1:0]                sel;
    logic [31:0]                     preset;
    logic [DATA_BYTES-1:0][7:0]      bytes;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [15:0]       errors;
    logic [3:0][7:0]   analog;
    logic [1:0][31:0]  total;
    logic [1:0][15:0]  delta;
  } port_rec_t;

  typedef struct packed {
    logic              good;
    logic [PORT_W-1:0] port;
    port_rec_t         rec;
  } result_t;

endpackage

// ===== rtl/cfa_front.sv =====
// front end: tracks frame bytes and checksum, issues frame and preset commands
module cfa_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         opcode,
  input  logic [cfa_pkg::PORT_W-1:0]   source_port,
  input  logic                         frame_start,
  input  logic [7:0]                   data_byte,
  input  logic [cfa_pkg::SEL_W-1:0]    encoder_select,
  input  logic [31:0]                  preset_value,
  output logic                         push,
  output cfa_pkg::cmd_t                cmd
);

  logic [cfa_pkg::POS_W-1:0] byte_position, byte_position_next, pos_eff;
  logic [7:0]                running_sum, running_sum_next, sum_eff;
  logic [cfa_pkg::DATA_BYTES-1:0][7:0] frame_store;
  logic                      is_data;

  always_comb begin
    pos_eff = frame_start ? '0 : byte_position;
    sum_eff = frame_start ? '0 : running_sum;
    is_data = pos_eff < cfa_pkg::POS_W'(cfa_pkg::DATA_BYTES);
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    push               = 1'b0;
    cmd.kind   = cfa_pkg::CMD_FRAME;
    cmd.port   = source_port;
    cmd.good   = (sum_eff == data_byte);
    cmd.sel    = encoder_select;
    cmd.preset = preset_value;
    cmd.bytes  = frame_store;
    if (accept) begin
      if (opcode == cfa_pkg::OP_PRESET) begin
        cmd.kind = cfa_pkg::CMD_PRESET;
        push     = int'(encoder_select) < cfa_pkg::ENC_COUNT;
      end else if (is_data) begin
        byte_position_next = pos_eff + cfa_pkg::POS_W'(1);
        running_sum_next   = (sum_eff + data_byte) & cfa_pkg::SUM_MASK;
      end else begin
        // checksum byte closes the frame
        byte_position_next = '0;
        running_sum_next   = '0;
        push               = int'(source_port) < cfa_pkg::PORT_COUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= '0;
    end else begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == cfa_pkg::OP_FRAME_BYTE && is_data) begin
      frame_store[pos_eff[cfa_pkg::BIDX_W-1:0]] <= data_byte;
    end
  end

endmodule

// ===== rtl/cfa_queue.sv =====
// short command queue between front end and back end
module cfa_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cfa_pkg::cmd_t      cmd_in,
  input  logic               pop,
  output cfa_pkg::cmd_t      cmd_out,
  output cfa_pkg::q_status_t status
);

  localparam int PTR_W = $clog2(cfa_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(cfa_pkg::QUEUE_DEPTH + 1);

  cfa_pkg::cmd_t     entries [cfa_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(cfa_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign status.full  = (count == CNT_W'(cfa_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign cmd_out      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= cmd_in;
  end

endmodule

// ===== rtl/cfa_back.sv =====
// back end: per-port totals and held values, result output register
module cfa_back (
  input  logic               clk,
  input  logic               rst,
  input  cfa_pkg::cmd_t      cmd,
  input  logic               cmd_valid,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_ready,
  output cfa_pkg::result_t   res
);

  cfa_pkg::port_rec_t ports [cfa_pkg::PORT_COUNT];
  cfa_pkg::port_rec_t rec_cur, rec_next;
  logic               pop_frame;
  logic [cfa_pkg::PORT_W-1:0] pre_port;
  logic                       pre_k;

  assign pop       = cmd_valid && (!res_valid || res_ready);
  assign pop_frame = pop && cmd.kind == cfa_pkg::CMD_FRAME;
  assign pre_port  = cmd.sel[cfa_pkg::SEL_W-1:1];
  assign pre_k     = cmd.sel[0];
  assign rec_cur   = ports[cmd.port];

  always_comb begin
    rec_next = rec_cur;
    if (cmd.good) begin
      // deltas are big-endian in the frame
      rec_next.delta[0]  = {cmd.bytes[0], cmd.bytes[1]};
      rec_next.delta[1]  = {cmd.bytes[2], cmd.bytes[3]};
      rec_next.analog[0] = cmd.bytes[4];
      rec_next.analog[1] = cmd.bytes[5];
      rec_next.analog[2] = cmd.bytes[6];
      rec_next.analog[3] = cmd.bytes[7];
      rec_next.total[0]  = rec_cur.total[0] + {{16{cmd.bytes[0][7]}}, cmd.bytes[0], cmd.bytes[1]};
      rec_next.total[1]  = rec_cur.total[1] + {{16{cmd.bytes[2][7]}}, cmd.bytes[2], cmd.bytes[3]};
    end else begin
      rec_next.errors = rec_cur.errors + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      for (int i = 0; i < cfa_pkg::PORT_COUNT; i++) begin
        ports[i] <= '0;
      end
    end else begin
      if (pop_frame) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (pop) begin
        if (cmd.kind == cfa_pkg::CMD_PRESET) begin
          ports[pre_port].total[pre_k] <= cmd.preset;
        end else begin
          ports[cmd.port] <= rec_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_frame) begin
      res.good <= cmd.good;
      res.port <= cmd.port;
      res.rec  <= rec_next;
    end
  end

endmodule

// ===== rtl/checksummed_encoder_frame_accumulator.sv =====
// top level of the checksummed encoder frame accumulator
// Takes one transfer per cycle while s_axis_tready is high, frame bytes or preset commands.
// A frame is eight data bytes and a checksum byte (8-bit sum of the data bytes); the
// checksum byte yields one result with the updated held values of its port. The frame
// command passes through the two-entry command queue, then the back end that updates the
// totals and loads the output register. Presets go through the same queue, so they apply
// in order with frames and yield no result. s_axis_tready drops only while the queue is
// full, which happens only while the output side stalls.
module checksummed_encoder_frame_accumulator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_byte, encoder_select, preset_value, zero fill
  input  logic [cfa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // opcode, source_port, frame_start
  input  logic [cfa_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // delta_first, delta_second, total_first, total_second,
  // analog_zero, analog_one, analog_two, analog_three, error_count
  output logic [cfa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // frame_port, frame_good
  output logic [cfa_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

  logic               in_accept;
  logic               q_push, q_pop;
  cfa_pkg::cmd_t      front_cmd, q_cmd;
  cfa_pkg::q_status_t q_status;
  cfa_pkg::result_t   res;

  assign s_axis_tready = !q_status.full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  cfa_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_accept),
    .opcode         (s_axis_tuser[0]),
    .source_port    (s_axis_tuser[1]),
    .frame_start    (s_axis_tuser[2]),
    .data_byte      (s_axis_tdata[7:0]),
    .encoder_select (s_axis_tdata[9:8]),
    .preset_value   (s_axis_tdata[41:10]),
    .push           (q_push),
    .cmd            (front_cmd)
  );

  cfa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (front_cmd),
    .pop     (q_pop),
    .cmd_out (q_cmd),
    .status  (q_status)
  );

  cfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_valid (!q_status.empty),
    .pop       (q_pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {res.rec.errors,
                         res.rec.analog[3], res.rec.analog[2],
                         res.rec.analog[1], res.rec.analog[0],
                         res.rec.total[1], res.rec.total[0],
                         res.rec.delta[1], res.rec.delta[0]};
  assign m_axis_tuser = {res.good, res.port};

  // a command is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !q_push)
    else $error("command pushed into full queue");

  // a frame command taken by the back end shows up as a result next cycle
  a_frame_result: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_cmd.kind == cfa_pkg::CMD_FRAME) |=> m_axis_tvalid)
    else $error("frame command produced no result");

  // the queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> q_status.empty)
    else $error("queue not empty after reset");

endmodule
